[design/gfba_pkg.sv]
// gfba_pkg: shared constants, status codes and controller/datapath structs
// for the grouped free-block allocator. No dependencies.
`default_nettype none

package gfba_pkg;

  // fixed field widths
  localparam int BLK_W  = 10;  // block number
  localparam int WORD_W = 11;  // stack / group word
  localparam int ST_W   = 2;   // result status

  localparam int GROUP_SIZE_DEF = 16;
  localparam int NUM_BLOCKS_DEF = 1024;

  localparam logic [WORD_W-1:0] END_MARK = 11'h7FF;

  localparam logic [ST_W-1:0] ST_ALLOC = 2'd0;
  localparam logic [ST_W-1:0] ST_FAIL  = 2'd1;
  localparam logic [ST_W-1:0] ST_FREED = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request, read top of stack
    logic pop;         // allocate from stack
    logic fail;        // allocate on empty list
    logic grp_start;   // leader allocate or spilling free: start group addressing
    logic push;        // free into stack
    logic mod_step;    // one step of block mod NUM_BLOCKS
    logic mul;         // group base address
    logic spill_rd;    // stack -> group store, one word
    logic spill_end;
    logic reload_rd;   // group store -> stack, one word
    logic reload_end;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_free;
    logic count_one;
    logic count_full;
    logic link_end;
    logic mod_last;
    logic sweep_last;
  } stat_t;

endpackage

`default_nettype wire

[design/gfba_ctrl.sv]
// gfba_ctrl: sequencing state machine for the allocator.
// Depends on gfba_pkg (cmd_t, stat_t).
`default_nettype none

module gfba_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire gfba_pkg::stat_t stat,
  output gfba_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOD,
    S_MUL,
    S_SPILL,
    S_RELOAD,
    S_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (!stat.req_free) begin
          if (!stat.count_one) begin
            cmd.pop = 1'b1;
          end else if (stat.link_end) begin
            cmd.fail = 1'b1;
          end else begin
            cmd.grp_start = 1'b1;
            state_nxt     = S_MOD;
          end
        end else begin
          if (!stat.count_full) begin
            cmd.push = 1'b1;
          end else begin
            cmd.grp_start = 1'b1;
            state_nxt     = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = stat.req_free ? S_SPILL : S_RELOAD;
      end
      S_SPILL: begin
        cmd.spill_rd = 1'b1;
        if (stat.sweep_last) begin
          cmd.spill_end = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RELOAD: begin
        cmd.reload_rd = 1'b1;
        if (stat.sweep_last) begin
          cmd.reload_end = 1'b1;
          state_nxt      = S_DRAIN;
        end
      end
      // last reloaded word lands in the stack here
      S_DRAIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy_nxt = (state_nxt != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_EXEC))
    else $error("accepted transaction did not enter execute");

  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy == (state_r != S_IDLE))
    else $error("busy out of step with state");

  a_drain_after_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> ($past(state_r) == S_RELOAD))
    else $error("drain entered without reload");

endmodule

`default_nettype wire

[design/gfba_dp.sv]
// gfba_dp: allocator datapath - stack, link, group store memory,
// modulo/base address unit and result registers. Depends on gfba_pkg.
`default_nettype none

module gfba_dp #(
  parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF,
  parameter int NUM_BLOCKS = gfba_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_req_type,
  input  wire logic [gfba_pkg::BLK_W-1:0] in_block_no,
  input  wire gfba_pkg::cmd_t             cmd,
  output gfba_pkg::stat_t                 stat,
  output logic                            out_valid,
  output logic [gfba_pkg::BLK_W-1:0]      out_alloc_block,
  output logic [gfba_pkg::ST_W-1:0]       out_status
);

  localparam int BLK_W  = gfba_pkg::BLK_W;
  localparam int WORD_W = gfba_pkg::WORD_W;
  localparam int ST_W   = gfba_pkg::ST_W;
  localparam int IDX_W  = $clog2(GROUP_SIZE);
  localparam int CNT_W  = $clog2(GROUP_SIZE + 1);
  localparam int DEPTH  = GROUP_SIZE * NUM_BLOCKS;
  localparam int ADDR_W = $clog2(DEPTH);
  // quotient = (block * MOD_M) >> MOD_SH, exact for every BLK_W-bit block
  localparam int MOD_SH = BLK_W + $clog2(NUM_BLOCKS);
  localparam int MOD_M  = ((1 << MOD_SH) + NUM_BLOCKS - 1) / NUM_BLOCKS;

  // request
  logic              req_r;
  logic [BLK_W-1:0]  blk_r;

  // stack: slot 0 lives in link_r
  logic [WORD_W-1:0] stk [GROUP_SIZE];
  logic [WORD_W-1:0] link_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data_r;

  // group addressing
  logic [BLK_W-1:0]  row_r;
  logic              mod_ph_r;
  logic [BLK_W-1:0]  quo_r;
  logic [31:0]       quo_full;
  logic [31:0]       quo_mul;
  logic [ADDR_W-1:0] base_r;
  logic [IDX_W-1:0]  idx_r;

  // group store and sweep pipeline
  logic [WORD_W-1:0] gmem [DEPTH];
  logic [ADDR_W-1:0] g_addr;
  logic [WORD_W-1:0] g_rd_r;
  logic              sp_v_r;
  logic [ADDR_W-1:0] sp_addr_r;
  logic              rl_v_r;
  logic [IDX_W-1:0]  rl_idx_r;

  logic              out_valid_r;
  logic [BLK_W-1:0]  out_blk_r;
  logic [ST_W-1:0]   out_st_r;

  assign rd_addr  = cmd.spill_rd ? idx_r : IDX_W'(count_r - CNT_W'(1));
  assign g_addr   = base_r + ADDR_W'(idx_r);
  assign quo_full = (32'(row_r) * 32'(MOD_M)) >> MOD_SH;
  assign quo_mul  = 32'(quo_r) * 32'(NUM_BLOCKS);

  assign stat.req_free   = req_r;
  assign stat.count_one  = (count_r == CNT_W'(1));
  assign stat.count_full = (count_r == CNT_W'(GROUP_SIZE));
  assign stat.link_end   = (link_r == gfba_pkg::END_MARK);
  assign stat.mod_last   = !mod_ph_r;
  assign stat.sweep_last = (idx_r == IDX_W'(GROUP_SIZE - 1));

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r      <= gfba_pkg::END_MARK;
      count_r     <= CNT_W'(1);
      sp_v_r      <= 1'b0;
      rl_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sp_v_r      <= cmd.spill_rd;
      rl_v_r      <= cmd.reload_rd;
      out_valid_r <= cmd.pop | cmd.fail | cmd.push | cmd.grp_start;
      if (cmd.pop)        count_r <= count_r - CNT_W'(1);
      if (cmd.push)       count_r <= count_r + CNT_W'(1);
      if (cmd.reload_end) count_r <= CNT_W'(GROUP_SIZE);
      if (cmd.spill_end) begin
        count_r <= CNT_W'(1);
        link_r  <= {1'b0, blk_r};
      end
      if (rl_v_r && rl_idx_r == '0) link_r <= g_rd_r;
    end
  end

  // stack array, one registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= (rd_addr == '0) ? link_r : stk[rd_addr];
    if (cmd.push) begin
      stk[IDX_W'(count_r)] <= {1'b0, blk_r};
    end else if (rl_v_r) begin
      stk[rl_idx_r] <= g_rd_r;
    end
  end

  // group store
  always_ff @(posedge clk) begin
    g_rd_r <= gmem[g_addr];
    if (sp_v_r) gmem[sp_addr_r] <= rd_data_r;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      blk_r <= in_block_no;
    end
    if (cmd.grp_start) begin
      row_r    <= req_r ? blk_r : link_r[BLK_W-1:0];
      mod_ph_r <= 1'b1;
    end
    // block mod NUM_BLOCKS: reciprocal quotient, then subtract quotient * NUM_BLOCKS
    if (cmd.mod_step) begin
      if (mod_ph_r) quo_r <= quo_full[BLK_W-1:0];
      else          row_r <= row_r - quo_mul[BLK_W-1:0];
      mod_ph_r <= 1'b0;
    end
    if (cmd.mul) begin
      base_r <= ADDR_W'(32'(row_r) * 32'(GROUP_SIZE));
      idx_r  <= '0;
    end
    if (cmd.spill_rd || cmd.reload_rd) idx_r <= idx_r + IDX_W'(1);
    sp_addr_r <= g_addr;
    rl_idx_r  <= idx_r;

    if (cmd.pop) begin
      out_blk_r <= rd_data_r[BLK_W-1:0];
      out_st_r  <= gfba_pkg::ST_ALLOC;
    end else if (cmd.fail) begin
      out_blk_r <= '0;
      out_st_r  <= gfba_pkg::ST_FAIL;
    end else if (cmd.push || (cmd.grp_start && req_r)) begin
      out_blk_r <= '0;
      out_st_r  <= gfba_pkg::ST_FREED;
    end else if (cmd.grp_start) begin
      out_blk_r <= link_r[BLK_W-1:0];
      out_st_r  <= gfba_pkg::ST_ALLOC;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_alloc_block = out_blk_r;
  assign out_status      = out_st_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(1)) && (count_r <= CNT_W'(GROUP_SIZE)))
    else $error("stack count out of range");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == gfba_pkg::ST_ALLOC || out_status == gfba_pkg::ST_FAIL ||
                   out_status == gfba_pkg::ST_FREED))
    else $error("illegal result status");

  a_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sp_v_r && rl_v_r))
    else $error("spill and reload overlap");

endmodule

`default_nettype wire

[design/grouped_free_block_allocator.sv]
// grouped_free_block_allocator: top level, grouped free-block list.
// Depends on gfba_pkg, gfba_ctrl, gfba_dp.
//
//  channel   ports                              transfer
//  input     start, busy, in_req_type,          start & !busy
//            in_block_no
//  result    out_valid, out_alloc_block,        out_valid, one cycle
//            out_status
//
// Plain allocate/free: the request is captured at accept, and the result is registered out of the execute state.
// Spill (free on full stack) and reload (allocate of the leader) pass through a
// two-step reciprocal block-mod unit, a base multiply and a one-word-per-cycle
// copy through the group store port; reload then drains the last word into the stack.
// Reset is synchronous, no clearing pass; the list starts empty.
// busy is high while a transaction is in flight; results cannot be stalled.
`default_nettype none

module grouped_free_block_allocator #(
  parameter int GROUP_SIZE = gfba_pkg::GROUP_SIZE_DEF,
  parameter int NUM_BLOCKS = gfba_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_req_type,
  input  wire logic [gfba_pkg::BLK_W-1:0] in_block_no,
  output logic                            out_valid,
  output logic [gfba_pkg::BLK_W-1:0]      out_alloc_block,
  output logic [gfba_pkg::ST_W-1:0]       out_status
);

  gfba_pkg::cmd_t  cmd;
  gfba_pkg::stat_t stat;

  gfba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  gfba_dp #(
    .GROUP_SIZE (GROUP_SIZE),
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_req_type     (in_req_type),
    .in_block_no     (in_block_no),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_alloc_block (out_alloc_block),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire
